// ----- hdl/amx_pkg.sv -----
// Shared constants, field codes and controller/datapath handshake types.
package amx_pkg;

    localparam int MODE_W     = 3;
    localparam int NODE_W     = 6;
    localparam int VAL_W      = 16;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 7;
    localparam int NODE_LIMIT = 64;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CNT_W-1:0] NODES_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUT_NB = 3'd4;
    localparam logic [MODE_W-1:0] MODE_IN_NB  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // Register index, taken from paddr[2].
    localparam logic REG_NODES_IN_USE = 1'b0;

    typedef struct packed {
        logic idle;         // read address follows the incoming word
        logic load;         // incoming word accepted this cycle
        logic clr_step;     // clearing pass writes one entry
        logic scan;         // scan in progress
        logic single_fire;  // single-entry result issued, write committed
        logic scan_adv;     // current scan entry consumed
        logic final_fire;   // closing list result issued
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_list;      // incoming word is a list request with a valid node
        logic hit;          // current entry is nonzero
        logic pend_valid;   // a neighbor is held back for its last mark
        logic scan_end;     // current entry is the final one of the scan
        logic out_free;     // output register can take a word
    } t_sts;

endpackage

// ----- hdl/amx_req_if.sv -----
// Request channel: one operation on the adjacency matrix.
interface amx_req_if import amx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] row_node;
    logic [NODE_W-1:0] col_node;
    logic              ignore_check;
    logic [VAL_W-1:0]  entry_value;

    modport source (output valid, mode, row_node, col_node, ignore_check, entry_value,
                    input ready);
    modport sink   (input valid, mode, row_node, col_node, ignore_check, entry_value,
                    output ready);
endinterface

// ----- hdl/amx_rsp_if.sv -----
// Response channel: one result word of an operation.
interface amx_rsp_if import amx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [NODE_W-1:0] neighbor_node;
    logic              neighbor_found;
    logic              last;

    modport source (output valid, status, read_value, neighbor_node, neighbor_found, last,
                    input ready);
    modport sink   (input valid, status, read_value, neighbor_node, neighbor_found, last,
                    output ready);
endinterface

// ----- hdl/amx_ram.sv -----
// Generic simple dual-port RAM with registered read.
module amx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/amx_ctrl.sv -----
// Controller state machine: clearing pass, request sequencing and scan control.
module amx_ctrl import amx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SINGLE,
        S_SCAN,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   stall;

    // A scan stalls only when a held neighbor must leave and the output is full.
    assign stall = i_sts.hit && i_sts.pend_valid && !i_sts.out_free;

    always_comb begin
        o_cmd             = '0;
        o_cmd.idle        = (r_state == S_IDLE);
        o_cmd.load        = (r_state == S_IDLE) && i_req_valid;
        o_cmd.clr_step    = (r_state == S_CLEAR);
        o_cmd.scan        = (r_state == S_SCAN);
        o_cmd.single_fire = (r_state == S_SINGLE) && i_sts.out_free;
        o_cmd.scan_adv    = (r_state == S_SCAN) && !stall;
        o_cmd.final_fire  = (r_state == S_FINAL) && i_sts.out_free;
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = i_sts.in_list ? S_SCAN : S_SINGLE;
            end
            S_SINGLE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (!stall && i_sts.scan_end) n_state = S_FINAL;
            end
            S_FINAL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/amx_dp.sv -----
// Datapath: matrix memory, request registers, scan index, held neighbor and output register.
module amx_dp import amx_pkg::*; #(
    parameter int NODES       = 64,
    parameter int ENTRY_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [CNT_W-1:0]  i_nodes_in_use,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [NODE_W-1:0] i_row_node,
    input  logic [NODE_W-1:0] i_col_node,
    input  logic              i_ignore_check,
    input  logic [VAL_W-1:0]  i_entry_value,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [VAL_W-1:0]  o_read_value,
    output logic [NODE_W-1:0] o_neighbor_node,
    output logic              o_neighbor_found,
    output logic              o_last
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIMIT = (NODES < NODE_LIMIT) ? NODES : NODE_LIMIT;
    localparam int EW    = ENTRY_WIDTH;

    function automatic logic [AW-1:0] amx_addr(input logic [CNT_W-1:0] row,
                                                input logic [CNT_W-1:0] col);
        amx_addr = AW'(AW'(row) * AW'(NODES)) + AW'(col);
    endfunction

    logic [CNT_W-1:0]  live_n;
    logic [CNT_W-1:0]  in_row;
    logic [CNT_W-1:0]  in_col;
    logic              in_is_list;
    logic              in_bad;

    logic [MODE_W-1:0] r_mode;
    logic [NODE_W-1:0] r_row;
    logic [NODE_W-1:0] r_col;
    logic              r_skip;
    logic [VAL_W-1:0]  r_val;
    logic              r_bad;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_pend_valid;
    logic [NODE_W-1:0] r_pend;
    logic [AW-1:0]     r_clr;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_read_value;
    logic [NODE_W-1:0] r_neighbor;
    logic              r_found;
    logic              r_last;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic              wr_en;
    logic [EW-1:0]     q;
    logic [31:0]       q_ext;
    logic              hit;
    logic              out_free;

    logic [STAT_W-1:0] s_status;
    logic [VAL_W-1:0]  s_read;
    logic              s_we;
    logic [EW-1:0]     s_wdata;

    assign live_n     = (i_nodes_in_use > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : i_nodes_in_use;
    assign in_row     = CNT_W'(i_row_node);
    assign in_col     = CNT_W'(i_col_node);
    assign in_is_list = (i_mode == MODE_OUT_NB) || (i_mode == MODE_IN_NB);
    assign in_bad     = (in_row >= live_n) || (!in_is_list && (in_col >= live_n));

    assign q_ext    = 32'(q);
    assign hit      = |q;
    assign out_free = !r_out_valid || i_rsp_ready;

    // Next scan index and memory read address.
    assign n_idx = i_cmd.scan_adv ? r_idx + CNT_W'(1) : r_idx;

    always_comb begin
        if (i_cmd.idle) begin
            if (i_mode == MODE_IN_NB) begin
                rd_addr = amx_addr('0, in_row);
            end else if (i_mode == MODE_OUT_NB) begin
                rd_addr = amx_addr(in_row, '0);
            end else begin
                rd_addr = amx_addr(in_row, in_col);
            end
        end else if (i_cmd.scan) begin
            rd_addr = (r_mode == MODE_IN_NB) ? amx_addr(n_idx, CNT_W'(r_row))
                                             : amx_addr(CNT_W'(r_row), n_idx);
        end else begin
            rd_addr = amx_addr(CNT_W'(r_row), CNT_W'(r_col));
        end
    end

    // Outcome of a single-entry request once its entry is on the read port.
    always_comb begin
        s_status = ST_OK;
        s_read   = '0;
        s_we     = 1'b0;
        s_wdata  = '0;
        if (r_mode > MODE_IN_NB) begin
            s_status = ST_OK;
        end else if (r_bad) begin
            s_status = ST_INVALID;
        end else begin
            case (r_mode)
                MODE_ADD: begin
                    if (!r_skip && hit) begin
                        s_status = ST_EXISTS;
                    end else begin
                        s_we    = 1'b1;
                        s_wdata = EW'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (!r_skip && !hit) begin
                        s_status = ST_NOT_FOUND;
                    end else begin
                        s_we = 1'b1;
                    end
                end
                MODE_READ: begin
                    s_read = q_ext[VAL_W-1:0];
                end
                MODE_WRITE: begin
                    s_we    = 1'b1;
                    s_wdata = EW'(r_val);
                end
                default: begin
                    s_status = ST_OK;
                end
            endcase
        end
    end

    assign wr_en   = i_cmd.clr_step || (i_cmd.single_fire && s_we);
    assign wr_addr = i_cmd.clr_step ? r_clr : amx_addr(CNT_W'(r_row), CNT_W'(r_col));
    assign wr_data = i_cmd.clr_step ? '0 : s_wdata;

    amx_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (q)
    );

    // Request registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_row  <= i_row_node;
            r_col  <= i_col_node;
            r_skip <= i_ignore_check;
            r_val  <= i_entry_value;
            r_bad  <= in_bad;
        end
        if (i_cmd.scan_adv && hit) begin
            r_pend <= r_idx[NODE_W-1:0];
        end
    end

    // Control registers: clear counter, scan index, held-neighbor flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                r_idx <= n_idx;
                if (i_cmd.scan_adv && hit) begin
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.single_fire || i_cmd.final_fire ||
                     (i_cmd.scan_adv && hit && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.single_fire) begin
            r_status     <= s_status;
            r_read_value <= s_read;
            r_neighbor   <= '0;
            r_found      <= 1'b0;
            r_last       <= 1'b1;
        end else if (i_cmd.scan_adv && hit && r_pend_valid) begin
            r_status     <= ST_OK;
            r_read_value <= '0;
            r_neighbor   <= r_pend;
            r_found      <= 1'b1;
            r_last       <= 1'b0;
        end else if (i_cmd.final_fire) begin
            r_status     <= ST_OK;
            r_read_value <= '0;
            r_neighbor   <= r_pend_valid ? r_pend : '0;
            r_found      <= r_pend_valid;
            r_last       <= 1'b1;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_read_value     = r_read_value;
    assign o_neighbor_node  = r_neighbor;
    assign o_neighbor_found = r_found;
    assign o_last           = r_last;

    assign o_sts.clr_done   = (r_clr == AW'(DEPTH - 1));
    assign o_sts.in_list    = in_is_list && (in_row < live_n);
    assign o_sts.hit        = hit;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.scan_end   = (r_idx == live_n - CNT_W'(1));
    assign o_sts.out_free   = out_free;

endmodule

// ----- hdl/adjacency_matrix_store_unit.sv -----
// Top level of the adjacency matrix store: register port, controller and datapath.
//
// This block keeps a NODES x NODES matrix of ENTRY_WIDTH-bit edge entries in one
// on-chip RAM, and performs one operation per request word: add, remove, read or
// write one entry, or list the out-neighbors (row scan) or in-neighbors (column
// scan) of a node. After reset a clearing pass writes zero into every one of the
// NODES*NODES entries (4096 at the default size), one entry per cycle; requests
// are not accepted during that time, while register writes are. A single-entry
// request first reads its entry through the registered RAM read port; then, once
// the response side can take a word, it checks the entry, commits the write and
// loads the result word into the output register. A list request reads one entry
// per cycle through the single RAM read port, except while a held neighbor must
// leave and the output is full; it produces one word per neighbor in increasing
// node order, the last of them marked, or one empty word with the last flag when
// there is none. The node count register nodes_in_use, at byte address 0, limits
// which node indices are valid; where used it is saturated to NODES and to 64,
// and is only to be written while the block is idle.
module adjacency_matrix_store_unit import amx_pkg::*; #(
    parameter int NODES       = 64,
    parameter int ENTRY_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Register port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Request and response channels.
    amx_req_if.sink            i_req,
    amx_rsp_if.source          o_rsp
);

    logic [CNT_W-1:0] r_nodes_in_use;
    logic             reg_sel;
    t_cmd             cmd;
    t_sts             sts;

    // The register is selected by address bit 2; anything above is unmapped.
    assign reg_sel = (paddr[2] == REG_NODES_IN_USE);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_in_use <= NODES_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_nodes_in_use <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(r_nodes_in_use) : '0;

    // The controller sequences the clearing pass and each request; the datapath
    // owns the RAM, the request registers and the output word register.
    amx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    amx_dp #(
        .NODES       (NODES),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_nodes_in_use   (r_nodes_in_use),
        .i_mode           (i_req.mode),
        .i_row_node       (i_req.row_node),
        .i_col_node       (i_req.col_node),
        .i_ignore_check   (i_req.ignore_check),
        .i_entry_value    (i_req.entry_value),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_read_value     (o_rsp.read_value),
        .o_neighbor_node  (o_rsp.neighbor_node),
        .o_neighbor_found (o_rsp.neighbor_found),
        .o_last           (o_rsp.last)
    );

endmodule
